// File: design/itfti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package itfti_pkg;

  localparam int unsigned SampleBitsDef   = 16;
  localparam int unsigned FractionBitsDef = 16;
  localparam int unsigned NumChannels     = 6;
  localparam int unsigned TimeBits        = 64;
  localparam int unsigned SkewBits        = 32;
  localparam int unsigned BudgetBits      = 8;
  localparam logic [SkewBits-1:0]   SkewReset   = 32'd50000000;
  localparam logic [BudgetBits-1:0] BudgetReset = 8'd100;
  localparam logic [BudgetBits-1:0] SpentMax    = 8'd255;

  localparam logic CfgMaxSkew = 1'b0;
  localparam logic CfgBudget  = 1'b1;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StTooOld   = 2'd1,
    StZeroIntv = 2'd2,
    StBudget   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BkIdle,
    BkDivide,
    BkMultiply,
    BkOutput
  } back_state_e;

  // Control word that the front part hands over with each job.
  typedef struct packed {
    status_e      status;
    logic         interp;
    logic [TimeBits-1:0] target;
  } job_ctrl_t;

endpackage
`default_nettype wire

// File: design/imu_to_frame_time_interpolator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A failure answer goes from the front part's one-entry queue straight to the output state;
// an interpolated answer first takes 16 division steps, a closing step and 6 multiplies.
// A word per cycle is taken unless a job waits while the back part is busy;
// the back part takes no new job until its answer has been accepted at the output.
// Reset: rst_ni is asynchronous and active low; it empties the window and the queue.
module imu_to_frame_time_interpolator_core #(
  parameter int unsigned SAMPLE_BITS   = itfti_pkg::SampleBitsDef,
  parameter int unsigned FRACTION_BITS = itfti_pkg::FractionBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata from bit 0: sample time, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z.
  input  wire logic [((64 + 6*SAMPLE_BITS + 7)/8)*8-1:0] s_axis_tdata,
  // tuser: kind.
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata from bit 0: frame_time_ns, out_gyro_x .. out_accel_z.
  output logic [((64 + 6*SAMPLE_BITS + 7)/8)*8-1:0] m_axis_tdata,
  // tuser: status.
  output logic [1:0]       m_axis_tuser,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  import itfti_pkg::*;

  localparam int unsigned ChW   = NumChannels * SAMPLE_BITS;
  localparam int unsigned DataW = ((TimeBits + ChW + 7) / 8) * 8;

  logic                 job_valid, job_ready;
  job_ctrl_t            job_ctrl;
  logic [TimeBits-1:0]  job_num, job_den, out_time;
  logic [ChW-1:0]       job_old, job_new, out_ch;

  // Configuration is always taken; indices beyond the two registers are dropped.
  assign cfg_ready_o = 1'b1;

  itfti_front #(.SampleBits(SAMPLE_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_kind_i     (s_axis_tuser),
    .in_ts_i       (s_axis_tdata[TimeBits-1:0]),
    .in_ch_i       (s_axis_tdata[TimeBits +: ChW]),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i[0]),
    .cfg_index_ok_i(cfg_index_i[7:1] == 7'd0),
    .cfg_data_i    (cfg_data_i),
    .job_valid_o   (job_valid),
    .job_ready_i   (job_ready),
    .job_ctrl_o    (job_ctrl),
    .job_num_o     (job_num),
    .job_den_o     (job_den),
    .job_old_o     (job_old),
    .job_new_o     (job_new)
  );

  itfti_back #(.SampleBits(SAMPLE_BITS), .FractionBits(FRACTION_BITS)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_ctrl_i  (job_ctrl),
    .job_num_i   (job_num),
    .job_den_i   (job_den),
    .job_old_i   (job_old),
    .job_new_i   (job_new),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_status_o(m_axis_tuser),
    .out_time_o  (out_time),
    .out_ch_o    (out_ch)
  );

  assign m_axis_tdata = DataW'({out_ch, out_time});
endmodule
`default_nettype wire

// File: design/itfti_front.sv
`timescale 1ns / 1ps
`default_nettype none
module itfti_front #(
  parameter int unsigned SampleBits = itfti_pkg::SampleBitsDef
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic                                  in_kind_i,
  input  wire logic [itfti_pkg::TimeBits-1:0]        in_ts_i,
  input  wire logic [itfti_pkg::NumChannels*SampleBits-1:0] in_ch_i,
  input  wire logic                                  cfg_valid_i,
  input  wire logic                                  cfg_index_i,
  input  wire logic                                  cfg_index_ok_i,
  input  wire logic [itfti_pkg::SkewBits-1:0]        cfg_data_i,
  output logic                                       job_valid_o,
  input  wire logic                                  job_ready_i,
  output itfti_pkg::job_ctrl_t                       job_ctrl_o,
  output logic [itfti_pkg::TimeBits-1:0]             job_num_o,
  output logic [itfti_pkg::TimeBits-1:0]             job_den_o,
  output logic [itfti_pkg::NumChannels*SampleBits-1:0] job_old_o,
  output logic [itfti_pkg::NumChannels*SampleBits-1:0] job_new_o
);
  import itfti_pkg::*;

  logic [SkewBits-1:0]   skew_q;
  logic [BudgetBits-1:0] budget_q;
  logic [TimeBits-1:0]   new_ts_q, target_q;
  logic [NumChannels*SampleBits-1:0] new_ch_q;
  logic [1:0]            held_q;
  logic                  pending_q;
  logic [BudgetBits-1:0] spent_q;

  // One-entry queue towards the back part.
  logic                  jv_q;
  job_ctrl_t             jc_q;
  logic [TimeBits-1:0]   jn_q, jd_q;
  logic [NumChannels*SampleBits-1:0] jo_q, jw_q;

  logic                  take;
  logic [1:0]            held_n;
  logic [BudgetBits-1:0] spent_n, budget_eff;
  logic                  too_old, bracket, emit;
  status_e               st;

  assign in_ready_o = !jv_q || job_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign budget_eff = (budget_q == '0) ? BudgetBits'(1) : budget_q;
  assign held_n     = (held_q == 2'd2) ? held_q : held_q + 2'd1;
  assign spent_n    = (spent_q == SpentMax) ? spent_q : spent_q + BudgetBits'(1);

  // Tests on the window after the incoming sample has shifted in.
  always_comb begin
    too_old = (in_ts_i < target_q) &&
              ((target_q - in_ts_i) > {{(TimeBits-SkewBits){1'b0}}, skew_q});
    bracket = (new_ts_q <= target_q) && (in_ts_i >= target_q);
    emit    = 1'b0;
    st      = StOk;
    if (!in_kind_i && pending_q) begin
      if (held_n == 2'd2 && too_old) begin
        emit = 1'b1;
        st   = StTooOld;
      end else if (held_n == 2'd2 && bracket) begin
        emit = 1'b1;
        st   = (in_ts_i == new_ts_q) ? StZeroIntv : StOk;
      end else if (spent_n >= budget_eff) begin
        emit = 1'b1;
        st   = StBudget;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skew_q    <= SkewReset;
      budget_q  <= BudgetReset;
      new_ts_q  <= '0;
      new_ch_q  <= '0;
      target_q  <= '0;
      held_q    <= '0;
      pending_q <= 1'b0;
      spent_q   <= '0;
      jv_q      <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_index_ok_i) begin
        case (cfg_index_i)
          CfgMaxSkew: skew_q   <= cfg_data_i;
          CfgBudget:  budget_q <= cfg_data_i[BudgetBits-1:0];
          default:    ;
        endcase
      end
      if (job_ready_i) jv_q <= 1'b0;
      if (take) begin
        if (in_kind_i) begin
          target_q  <= in_ts_i;
          pending_q <= 1'b1;
          spent_q   <= '0;
        end else begin
          new_ts_q <= in_ts_i;
          new_ch_q <= in_ch_i;
          held_q   <= held_n;
          if (pending_q) spent_q <= spent_n;
          if (emit) begin
            pending_q <= 1'b0;
            jv_q      <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      jc_q.status <= st;
      jc_q.interp <= (st == StOk);
      jc_q.target <= target_q;
      jn_q        <= target_q - new_ts_q;
      jd_q        <= in_ts_i - new_ts_q;
      jo_q        <= new_ch_q;
      jw_q        <= in_ch_i;
    end
  end

  assign job_valid_o = jv_q;
  assign job_ctrl_o  = jc_q;
  assign job_num_o   = jn_q;
  assign job_den_o   = jd_q;
  assign job_old_o   = jo_q;
  assign job_new_o   = jw_q;
endmodule
`default_nettype wire

// File: design/itfti_back.sv
`timescale 1ns / 1ps
`default_nettype none
module itfti_back #(
  parameter int unsigned SampleBits   = itfti_pkg::SampleBitsDef,
  parameter int unsigned FractionBits = itfti_pkg::FractionBitsDef
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    job_valid_i,
  output logic                                         job_ready_o,
  input  itfti_pkg::job_ctrl_t                         job_ctrl_i,
  input  wire logic [itfti_pkg::TimeBits-1:0]          job_num_i,
  input  wire logic [itfti_pkg::TimeBits-1:0]          job_den_i,
  input  wire logic [itfti_pkg::NumChannels*SampleBits-1:0] job_old_i,
  input  wire logic [itfti_pkg::NumChannels*SampleBits-1:0] job_new_i,
  output logic                                         out_valid_o,
  input  wire logic                                    out_ready_i,
  output logic [1:0]                                   out_status_o,
  output logic [itfti_pkg::TimeBits-1:0]               out_time_o,
  output logic [itfti_pkg::NumChannels*SampleBits-1:0] out_ch_o
);
  import itfti_pkg::*;

  localparam int unsigned AlphaBits = FractionBits + 1;
  localparam int unsigned DiffBits  = SampleBits + 1;
  localparam int unsigned ProdBits  = AlphaBits + DiffBits + 1;
  localparam int unsigned CntBits   = $clog2(FractionBits + 1);
  localparam int unsigned ChBits    = $clog2(NumChannels);

  back_state_e state_q, state_d;
  logic [CntBits-1:0]  cnt_q;
  logic [ChBits-1:0]   ch_q;
  logic [TimeBits:0]   rem_q;
  logic [TimeBits-1:0] den_q;
  logic [AlphaBits-1:0] q_q;
  logic [1:0]          st_q;
  logic [TimeBits-1:0] tgt_q;
  logic [NumChannels*SampleBits-1:0] old_q, new_q, res_q;

  logic [TimeBits:0]   rem_sh;
  logic                ge;
  logic signed [SampleBits-1:0] a_s, b_s;
  logic signed [DiffBits-1:0]   diff;
  logic signed [ProdBits-1:0]   prod;
  logic signed [ProdBits-1:0]   shifted;
  logic [SampleBits-1:0]        res_ch;

  assign rem_sh = {rem_q[TimeBits-1:0], 1'b0};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign a_s    = old_q[ch_q*SampleBits +: SampleBits];
  assign b_s    = new_q[ch_q*SampleBits +: SampleBits];
  assign diff   = DiffBits'(b_s) - DiffBits'(a_s);
  assign prod   = $signed({1'b0, q_q}) * diff;
  assign shifted = prod >>> FractionBits;
  assign res_ch = SampleBits'(ProdBits'(a_s) + shifted);

  assign job_ready_o  = (state_q == BkIdle);
  assign out_valid_o  = (state_q == BkOutput);
  assign out_status_o = st_q;
  assign out_time_o   = tgt_q;
  assign out_ch_o     = res_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BkIdle:     if (job_valid_i) state_d = job_ctrl_i.interp ? BkDivide : BkOutput;
      BkDivide:   if (cnt_q == CntBits'(FractionBits)) state_d = BkMultiply;
      BkMultiply: if (ch_q == ChBits'(NumChannels - 1)) state_d = BkOutput;
      BkOutput:   if (out_ready_i) state_d = BkIdle;
      default:    state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      cnt_q   <= '0;
      ch_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == BkIdle) begin
        cnt_q <= '0;
        ch_q  <= '0;
      end
      if (state_q == BkDivide) cnt_q <= cnt_q + CntBits'(1);
      if (state_q == BkMultiply) ch_q <= ch_q + ChBits'(1);
    end
  end

  // Restoring division one quotient bit a cycle, then one channel a cycle.
  always_ff @(posedge clk_i) begin
    case (state_q)
      BkIdle: begin
        if (job_valid_i) begin
          st_q  <= job_ctrl_i.status;
          tgt_q <= job_ctrl_i.target;
          den_q <= job_den_i;
          old_q <= job_old_i;
          new_q <= job_new_i;
          res_q <= '0;
          if (job_num_i >= job_den_i) begin
            rem_q <= {1'b0, job_num_i - job_den_i};
            q_q   <= AlphaBits'(1);
          end else begin
            rem_q <= {1'b0, job_num_i};
            q_q   <= '0;
          end
        end
      end
      BkDivide: begin
        if (cnt_q != CntBits'(FractionBits)) begin
          rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
          q_q   <= {q_q[AlphaBits-2:0], ge};
        end
      end
      BkMultiply: res_q[ch_q*SampleBits +: SampleBits] <= res_ch;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// File: verif/imu_to_frame_time_interpolator_core_tb.sv
`timescale 1ns / 1ps
module imu_to_frame_time_interpolator_core_tb;
  import itfti_pkg::*;

  localparam int unsigned SB = SampleBitsDef;
  localparam int unsigned FB = FractionBitsDef;
  localparam int unsigned DW = ((64 + 6*SB + 7)/8)*8;
  localparam int unsigned WatchLimit = 4000;
  localparam logic KindImu = 1'b0;
  localparam logic KindCam = 1'b1;

  typedef logic signed [SB-1:0] chan_t;
  typedef struct packed {
    status_e     status;
    logic [63:0] frame_time;
    chan_t [5:0] chans;
  } answer_t;

  // Keeps its own copy of the window, the target and the registers, and holds
  // the answers still owed by the block in arrival order.
  class frame_answer_board;
    logic [31:0] skew_limit;
    logic [7:0]  budget;
    logic [63:0] old_time, new_time, target;
    chan_t       old_ch[6], new_ch[6];
    int          held;
    bit          pending;
    int          spent;
    answer_t     owed[$];
    int          errors, answers_seen, ok_seen, fail_seen;

    function new();
      skew_limit = SkewReset;
      budget = BudgetReset;
      old_time = 0; new_time = 0; target = 0;
      foreach (old_ch[j]) begin old_ch[j] = 0; new_ch[j] = 0; end
      held = 0; pending = 0; spent = 0;
      errors = 0; answers_seen = 0; ok_seen = 0; fail_seen = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] val);
      if (idx == 8'(CfgMaxSkew)) skew_limit = val;
      else if (idx == 8'(CfgBudget)) budget = val[7:0];
    endfunction

    function void give(status_e st, chan_t ch[6]);
      answer_t a;
      a.status = st;
      a.frame_time = target;
      for (int j = 0; j < 6; j++) a.chans[j] = (st == StOk) ? ch[j] : '0;
      owed.insert(owed.size(), a);
      pending = 0;
    endfunction

    // Long division of the time offset by the bracket width, FB fraction bits.
    function logic [63:0] time_fraction(logic [63:0] n, logic [63:0] d);
      logic [64:0] r;
      logic [63:0] q;
      q = 0;
      r = {1'b0, n};
      if (r >= {1'b0, d}) begin q = 1; r = r - {1'b0, d}; end
      for (int i = 0; i < FB; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= {1'b0, d}) begin r = r - {1'b0, d}; q[0] = 1'b1; end
      end
      return q;
    endfunction

    function void note_input(logic kind, logic [63:0] ts, chan_t ch[6]);
      logic [63:0] d, alpha;
      longint signed p, diff, shifted;
      chan_t res[6];
      if (kind == KindCam) begin
        target = ts; pending = 1; spent = 0;
        return;
      end
      old_time = new_time;
      new_time = ts;
      for (int j = 0; j < 6; j++) begin old_ch[j] = new_ch[j]; new_ch[j] = ch[j]; end
      if (held < 2) held++;
      if (!pending) return;
      if (spent < 255) spent++;
      if (held >= 2) begin
        if (new_time < target && (target - new_time) > {32'd0, skew_limit}) begin
          give(StTooOld, res);
          return;
        end
        if (old_time <= target && new_time >= target) begin
          d = new_time - old_time;
          if (d == 0) begin
            give(StZeroIntv, res);
            return;
          end
          alpha = time_fraction(target - old_time, d);
          for (int j = 0; j < 6; j++) begin
            diff = longint'(new_ch[j]) - longint'(old_ch[j]);
            p = longint'(alpha) * diff;
            shifted = p >>> FB;
            res[j] = chan_t'(longint'(old_ch[j]) + shifted);
          end
          give(StOk, res);
          return;
        end
      end
      if (spent >= ((budget == 0) ? 1 : budget)) give(StBudget, res);
    endfunction

    function void check_answer(logic [1:0] st, logic [DW-1:0] data);
      answer_t e;
      chan_t got;
      string ch_name[6] = '{"out_gyro_x", "out_gyro_y", "out_gyro_z",
                            "out_accel_x", "out_accel_y", "out_accel_z"};
      answers_seen++;
      if (owed.size() == 0) begin
        $error("answer arrived with none owed: status %0d time %0h", st, data[63:0]);
        errors++;
        return;
      end
      e = owed[0];
      owed.delete(0);
      if (e.status == StOk) ok_seen++; else fail_seen++;
      if (st != e.status) begin
        $error("status: expected %0d, got %0d", e.status, st); errors++;
      end
      if (data[63:0] !== e.frame_time) begin
        $error("frame_time_ns: expected %0h, got %0h", e.frame_time, data[63:0]);
        errors++;
      end
      for (int j = 0; j < 6; j++) begin
        got = data[64 + j*SB +: SB];
        if (got !== e.chans[j]) begin
          $error("%s: expected %0d, got %0d", ch_name[j], e.chans[j], got); errors++;
        end
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid = 0, s_axis_tuser = 0, m_axis_tready = 0;
  logic [DW-1:0] s_axis_tdata = '0;
  logic s_axis_tready, m_axis_tvalid;
  logic [DW-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [7:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  frame_answer_board board = new();
  int idle_cycles = 0;
  int words_sent = 0;
  bit stim_done = 0;
  logic [63:0] clock_ns = 64'd1000;

  always begin #2 clk_i = 1; #2 clk_i = 0; end

  imu_to_frame_time_interpolator_core u_top (.*);

  // Receiver: random ready gaps, one check per accepted answer word.
  initial begin
    int gap;
    @(posedge clk_i iff rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        m_axis_tready <= 0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1;
      @(posedge clk_i iff m_axis_tvalid);
      board.check_answer(m_axis_tuser, m_axis_tdata);
    end
  end

  // Watchdog on cycles with no accepted word on any channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni || stim_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog: no progress for %0d cycles", WatchLimit);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // The valid line stays high between words sent with no gap; it is dropped
  // before a gap and when the sender holds off.
  task automatic send_word(logic kind, logic [63:0] ts, chan_t ch[6], bit busy_ok = 1);
    logic [DW-1:0] w;
    int gap;
    w = '0;
    w[63:0] = ts;
    for (int j = 0; j < 6; j++) w[64 + j*SB +: SB] = ch[j];
    gap = (busy_ok && $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= kind;
    s_axis_tdata <= w;
    @(posedge clk_i iff s_axis_tready);
    board.note_input(kind, ts, ch);
    words_sent++;
  endtask

  task automatic random_chans(output chan_t ch[6]);
    for (int j = 0; j < 6; j++) begin
      case ($urandom_range(0, 4))
        0: ch[j] = chan_t'(1 << (SB-1));
        1: ch[j] = chan_t'((1 << (SB-1)) - 1);
        default: ch[j] = chan_t'($urandom());
      endcase
    end
  endtask

  task automatic imu(logic [63:0] ts);
    chan_t ch[6];
    random_chans(ch);
    send_word(KindImu, ts, ch);
  endtask

  task automatic camera(logic [63:0] ts);
    chan_t ch[6];
    foreach (ch[j]) ch[j] = chan_t'($urandom());
    send_word(KindCam, ts, ch);
  endtask

  // Stops sending, waits for all owed answers, then the latency of a late
  // interpolation.
  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.owed.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    drain();
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i iff cfg_ready_o);
    board.write_reg(idx, val);
    cfg_valid_i <= 0;
  endtask

  // One well formed frame: camera time, then IMU samples stepping through it.
  task automatic frame_sequence();
    logic [63:0] step, t_cam;
    int n_lead, n_trail;
    step = $urandom_range(1, 2000);
    t_cam = clock_ns + $urandom_range(0, 3000);
    n_lead = $urandom_range(0, 3);
    n_trail = $urandom_range(1, 3);
    for (int i = 0; i < n_lead; i++) begin
      imu(clock_ns);
      clock_ns += step;
    end
    camera(t_cam);
    for (int i = 0; i < n_trail + 2; i++) begin
      case ($urandom_range(0, 9))
        0: imu(clock_ns - step);
        1: imu(t_cam);
        default: imu(clock_ns);
      endcase
      clock_ns += ($urandom_range(0, 15) == 0) ? 0 : step;
    end
  endtask

  initial begin
    chan_t zeros[6], hi[6], lo[6];
    logic [63:0] r64;
    foreach (zeros[j]) begin zeros[j] = 0; hi[j] = chan_t'((1 << (SB-1)) - 1);
      lo[j] = chan_t'(1 << (SB-1)); end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: bracket at both ends, too old, budget, retarget.
    send_word(KindImu, 64'd100, lo);
    send_word(KindImu, 64'd200, hi);
    send_word(KindCam, 64'd200, zeros);
    send_word(KindImu, 64'd300, lo);
    send_word(KindCam, 64'd300, zeros);
    send_word(KindImu, 64'd400, hi);
    send_word(KindCam, 64'd450, zeros);
    send_word(KindImu, 64'd450, zeros);
    send_word(KindImu, 64'd450, hi);
    send_word(KindCam, '1, zeros);
    send_word(KindImu, 64'd500, lo);
    send_word(KindCam, 64'hFFFF_FFFF_FFFF_FFF0, zeros);
    send_word(KindCam, 64'hFFFF_FFFF_FFFF_FFFE, zeros);
    send_word(KindImu, 64'hFFFF_FFFF_FFFF_FFFD, hi);
    send_word(KindImu, '1, lo);
    write_reg(8'(CfgBudget), 32'd1);
    write_reg(8'(CfgMaxSkew), 32'hFFFF_FFFF);
    send_word(KindCam, 64'd0, zeros);
    send_word(KindImu, 64'd10, hi);
    send_word(KindCam, 64'd5, zeros);
    send_word(KindImu, 64'd0, lo);
    write_reg(8'(CfgMaxSkew), 32'd0);
    write_reg(8'(CfgBudget), 32'd0);
    write_reg(8'd7, 32'd12345);
    send_word(KindCam, 64'd100, zeros);
    send_word(KindImu, 64'd99, hi);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin write_reg(8'(CfgMaxSkew), SkewReset); write_reg(8'(CfgBudget), 8'd255); end
        1: begin write_reg(8'(CfgMaxSkew), 32'd500); write_reg(8'(CfgBudget), 8'd3); end
        2: begin write_reg(8'(CfgMaxSkew), 32'd0); write_reg(8'(CfgBudget), 8'd1); end
        3: begin write_reg(8'(CfgMaxSkew), '1); write_reg(8'(CfgBudget), 8'd8); end
        default: begin write_reg(8'(CfgMaxSkew), $urandom()); write_reg(8'(CfgBudget),
          $urandom_range(1, 255)); end
      endcase
      for (int k = 0; k < 40; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          r64 = {$urandom(), $urandom()};
          if ($urandom_range(0, 1)) camera(r64); else imu(r64);
          clock_ns = r64 >> 1;
        end else begin
          frame_sequence();
        end
      end
      if (phase == 2) drain(); // sender holds off until nothing is owed
    end

    drain();
    stim_done = 1;
    $display("sent %0d words; answers: %0d interpolated, %0d failure",
             words_sent, board.ok_seen, board.fail_seen);
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// File: imu_to_frame_time_interpolator_core.f
design/itfti_pkg.sv
design/itfti_front.sv
design/itfti_back.sv
design/imu_to_frame_time_interpolator_core.sv
verif/imu_to_frame_time_interpolator_core_tb.sv
